>>> sv/text_line_number_visualize_filter_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the text line filter
// Shared property shapes used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_NUMBER_VISUALIZE_FILTER_CORE_DEFINES_SVH
`define TEXT_LINE_NUMBER_VISUALIZE_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TLNV_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TLNV_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every edge including reset.
`define TLNV_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/tlnv_pkg.sv
// ----------------------------------------------------------------------------
// tlnv_pkg
// Types, constants and helper functions of the text line filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tlnv_pkg;

    localparam int NUMBER_DIGITS = 6;
    localparam int BCD_W         = 4 * NUMBER_DIGITS;
    localparam int DIG_W         = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
    localparam logic [DIG_W-1:0] DIG_LAST = DIG_W'(NUMBER_DIGITS - 1);
    localparam logic [BCD_W-1:0] BCD_ONE  = BCD_W'(1);

    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_ADDR_W = 3;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_CTRL_OFS = 8'h40;
    localparam logic [7:0] CH_CTRL_END = 8'h20;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_NUMBER_NONBLANK  = 3'd0,
        REG_NUMBER_ALL       = 3'd1,
        REG_SQUEEZE_BLANK    = 3'd2,
        REG_SHOW_ENDS        = 3'd3,
        REG_SHOW_TABS        = 3'd4,
        REG_SHOW_NONPRINTING = 3'd5
    } cfg_reg_t;

    // One expansion job: optional number text, optional prefix, final byte.
    typedef struct packed {
        logic                            num_en;
        logic [NUMBER_DIGITS-1:0][7:0]   num_text;  // [NUMBER_DIGITS-1] printed first
        logic                            pre_en;
        logic [7:0]                      pre_byte;
        logic [7:0]                      fin_byte;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Saturating BCD increment.
    function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        logic             carry;
        logic             all9;
        r     = v;
        carry = 1'b1;
        all9  = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (v[4*i +: 4] != 4'd9) all9 = 1'b0;
        end
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (carry) begin
                if (v[4*i +: 4] == 4'd9) begin
                    r[4*i +: 4] = 4'd0;
                end else begin
                    r[4*i +: 4] = v[4*i +: 4] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        return all9 ? v : r;
    endfunction

    // Right-aligned decimal text, leading zeros shown as spaces.
    function automatic logic [NUMBER_DIGITS-1:0][7:0] bcd_text(input logic [BCD_W-1:0] v);
        logic [NUMBER_DIGITS-1:0][7:0] t;
        logic                          lead;
        lead = 1'b1;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
            if (v[4*i +: 4] != 4'd0 || i == 0) lead = 1'b0;
            t[i] = lead ? CH_SPACE : (CH_ZERO + {4'h0, v[4*i +: 4]});
        end
        return t;
    endfunction

endpackage

`default_nettype wire

>>> sv/tlnv_front.sv
// ----------------------------------------------------------------------------
// tlnv_front
// Holds the options and line state, classifies each input byte into a job.
// ----------------------------------------------------------------------------
`default_nettype none

module tlnv_front import tlnv_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic                  cfg_wdata,
    input  wire logic                  in_accept,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  file_start,
    output      logic                  push,
    output      job_t                  push_job
);

    logic number_nonblank_reg, number_all_reg, squeeze_blank_reg;
    logic show_ends_reg, show_tabs_reg, show_nonprinting_reg;

    logic [BCD_W-1:0] line_number_reg, line_number_next;
    logic             after_newline_reg, after_newline_next;
    logic [1:0]       blank_run_reg, blank_run_next;

    logic [BCD_W-1:0] ln_cur;
    logic             an_cur;
    logic [1:0]       br_cur;
    logic             is_nl, is_tab, is_ctrl, drop, num_en;
    cfg_reg_t         cfg_sel;

    assign cfg_sel = cfg_reg_t'(cfg_addr);

    always_comb begin
        // apply file start before anything else
        ln_cur = file_start ? BCD_ONE : line_number_reg;
        an_cur = file_start ? 1'b1 : after_newline_reg;
        br_cur = file_start ? 2'd0 : blank_run_reg;

        is_nl   = (data_byte == CH_NL);
        is_tab  = (data_byte == CH_TAB);
        is_ctrl = ((data_byte < CH_CTRL_END) || (data_byte == CH_DEL)) && !is_nl && !is_tab;

        if (squeeze_blank_reg && is_nl && an_cur) begin
            blank_run_next = (br_cur < 2'd2) ? br_cur + 2'd1 : br_cur;
        end else begin
            blank_run_next = 2'd0;
        end
        drop = (blank_run_next > 2'd1);

        num_en = an_cur && ((number_nonblank_reg && !is_nl) ||
                            (number_all_reg && !number_nonblank_reg));

        line_number_next   = (num_en && !drop) ? bcd_inc(ln_cur) : ln_cur;
        after_newline_next = drop ? an_cur : is_nl;

        push_job.num_en   = num_en;
        push_job.num_text = bcd_text(ln_cur);
        push_job.pre_en   = (show_tabs_reg && is_tab) || (show_ends_reg && is_nl) ||
                            (show_nonprinting_reg && is_ctrl);
        push_job.pre_byte = (show_ends_reg && is_nl) ? CH_DOLLAR : CH_CARET;
        if (show_tabs_reg && is_tab) begin
            push_job.fin_byte = CH_I;
        end else if (show_nonprinting_reg && is_ctrl) begin
            push_job.fin_byte = (data_byte == CH_DEL) ? CH_QMARK : data_byte + CH_CTRL_OFS;
        end else begin
            push_job.fin_byte = data_byte;
        end

        push = in_accept && !drop;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            number_nonblank_reg  <= 1'b0;
            number_all_reg       <= 1'b0;
            squeeze_blank_reg    <= 1'b0;
            show_ends_reg        <= 1'b0;
            show_tabs_reg        <= 1'b0;
            show_nonprinting_reg <= 1'b0;
            line_number_reg      <= BCD_ONE;
            after_newline_reg    <= 1'b1;
            blank_run_reg        <= 2'd0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_sel)
                    REG_NUMBER_NONBLANK:  number_nonblank_reg  <= cfg_wdata;
                    REG_NUMBER_ALL:       number_all_reg       <= cfg_wdata;
                    REG_SQUEEZE_BLANK:    squeeze_blank_reg    <= cfg_wdata;
                    REG_SHOW_ENDS:        show_ends_reg        <= cfg_wdata;
                    REG_SHOW_TABS:        show_tabs_reg        <= cfg_wdata;
                    REG_SHOW_NONPRINTING: show_nonprinting_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (in_accept) begin
                line_number_reg   <= line_number_next;
                after_newline_reg <= after_newline_next;
                blank_run_reg     <= blank_run_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/tlnv_queue.sv
// ----------------------------------------------------------------------------
// tlnv_queue
// Short job queue between the classifier and the expander.
// ----------------------------------------------------------------------------
`default_nettype none

module tlnv_queue import tlnv_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head_job,
    output q_stat_t   stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign stat     = '{full: (count_reg == CNT_FULL), empty: (count_reg == '0)};
    assign head_job = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop) count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> sv/tlnv_back.sv
// ----------------------------------------------------------------------------
// tlnv_back
// Expands the queue head job into output bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module tlnv_back import tlnv_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire job_t       head_job,
    input  wire q_stat_t    stat,
    output      logic       pop,
    output      logic       m_tvalid,
    input  wire logic       m_tready,
    output      logic [7:0] m_tdata,
    output      logic       m_tlast
);

    typedef enum logic [2:0] {
        PH_FRESH,
        PH_NUM,
        PH_TAB,
        PH_PRE,
        PH_FIN
    } phase_t;

    phase_t           phase_reg, phase_next, phase_cur;
    logic [DIG_W-1:0] digit_reg, digit_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [7:0]       m_tdata_reg, m_tdata_next;
    logic             m_tlast_reg, m_tlast_next;
    logic             load, step;

    assign load = !m_tvalid_reg || m_tready;
    assign step = load && !stat.empty;

    always_comb begin
        // a fresh job starts at its first present part
        if (phase_reg == PH_FRESH) begin
            if (head_job.num_en)      phase_cur = PH_NUM;
            else if (head_job.pre_en) phase_cur = PH_PRE;
            else                      phase_cur = PH_FIN;
        end else begin
            phase_cur = phase_reg;
        end

        phase_next    = phase_reg;
        digit_next    = digit_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        pop           = 1'b0;

        if (step) begin
            m_tvalid_next = 1'b1;
            m_tlast_next  = 1'b0;
            unique case (phase_cur)
                PH_NUM: begin
                    m_tdata_next = head_job.num_text[digit_reg];
                    if (digit_reg == '0) begin
                        phase_next = PH_TAB;
                    end else begin
                        phase_next = PH_NUM;
                        digit_next = digit_reg - 1'b1;
                    end
                end
                PH_TAB: begin
                    m_tdata_next = CH_TAB;
                    phase_next   = head_job.pre_en ? PH_PRE : PH_FIN;
                end
                PH_PRE: begin
                    m_tdata_next = head_job.pre_byte;
                    phase_next   = PH_FIN;
                end
                default: begin
                    m_tdata_next = head_job.fin_byte;
                    m_tlast_next = 1'b1;
                    phase_next   = PH_FRESH;
                    digit_next   = DIG_LAST;
                    pop          = 1'b1;
                end
            endcase
        end else if (load) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_FRESH;
            digit_reg    <= DIG_LAST;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            digit_reg    <= digit_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tlast_reg  <= m_tlast_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

>>> sv/text_line_number_visualize_filter_core.sv
// ----------------------------------------------------------------------------
// text_line_number_visualize_filter_core
// Byte-stream text filter: blank squeeze, line numbers, visible ends/tabs/ctrl.
// ----------------------------------------------------------------------------
//
//   channel   direction   payload                          handshake
//   s_*       in          tdata[7:0] data_byte             tvalid/tready
//                         tuser      file_start
//   m_*       out         tdata[7:0] out_byte              tvalid/tready
//                         tlast      last_of_run
//   cfg_*     in          cfg_addr -> register, cfg_wdata  cfg_we (no wait)
//
// Plain bytes go in and out at one item per cycle while the output is ready;
// the input is taken every cycle while the two-entry job queue has room.
// A numbered line adds NUMBER_DIGITS digits and a tab to the output and a
// caret or dollar prefix one byte more; the expander emits one byte per
// cycle, so the queue fills and the input stalls until those bytes drain.
// Reset (aresetn low, synchronous) clears options, empties the queue and
// restarts numbering at one; output stalls hold the queue and then the input.
// ----------------------------------------------------------------------------
`default_nettype none

module text_line_number_visualize_filter_core import tlnv_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic                  cfg_wdata,
    // input bytes
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] data_byte
    input  wire logic                  s_tuser,   // [0] file_start
    // formatted bytes
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [7:0]            m_tdata,   // [7:0] out_byte
    output      logic                  m_tlast
);

    logic    in_accept;
    logic    push, pop;
    job_t    push_job, head_job;
    q_stat_t stat;

    // take a byte whenever the queue can hold its job; squeezed bytes
    // are taken too but leave no job behind
    assign s_tready  = !stat.full;
    assign in_accept = s_tvalid && s_tready;

    // classify: update line state and build the expansion job
    tlnv_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_accept  (in_accept),
        .data_byte  (s_tdata),
        .file_start (s_tuser),
        .push       (push),
        .push_job   (push_job)
    );

    // decouple classifier from expander
    tlnv_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .stat     (stat)
    );

    // expand: number digits, tab, prefix, final byte into the output register
    tlnv_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .stat     (stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> sv/tlnv_checker.sv
// ----------------------------------------------------------------------------
// tlnv_checker
// Port-level checks on the text line filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_line_number_visualize_filter_core_defines.svh"

module tlnv_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    `TLNV_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output changed")

    `TLNV_ASSERT_NEXT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_tvalid, "output valid right after reset")

    `TLNV_ASSERT_NOW(a_mid_run_byte, aclk, aresetn, m_tvalid && !m_tlast, m_tdata == 8'h20 || m_tdata == 8'h09 || m_tdata == 8'h5E || m_tdata == 8'h24 || (m_tdata >= 8'h30 && m_tdata <= 8'h39), "unexpected byte inside an expansion")

    `TLNV_ASSERT_NEXT(a_run_no_gap, aclk, aresetn, m_tvalid && !m_tlast, m_tvalid, "gap inside an expansion")

endmodule

bind text_line_number_visualize_filter_core tlnv_checker u_tlnv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

>>> verif/tb_text_line_number_visualize_filter_core.sv
// ----------------------------------------------------------------------------
// tb_text_line_number_visualize_filter_core
// Self-checking bench for the text line filter. A byte queue feeds a clocked
// stream driver. A behavioral formatter predicts every output byte and its
// end-of-run flag. A clocked monitor checks the output stream in order, while
// both sides stall at random. Directed text covers extremes and special cases.
// After it, random text with line structure runs under a series of option
// settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_text_line_number_visualize_filter_core import tlnv_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          OPT_COUNT    = 6;      // one bit per option register
    localparam int          DRAIN_CYCLES = 16;     // worst expansion plus pipeline slack
    localparam int          HOLD_CYCLES  = 200;    // long output back-pressure stretch
    localparam int unsigned GAP_MAX      = 14;
    localparam longint      LIMIT_NS     = 5_000_000;

    // Characters the formatter produces or reacts to
    localparam logic [7:0] CHR_NL     = 8'h0A;
    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_CARET  = 8'h5E;
    localparam logic [7:0] CHR_DOLLAR = 8'h24;
    localparam logic [7:0] CHR_LTR_I  = 8'h49;
    localparam logic [7:0] CHR_QMARK  = 8'h3F;
    localparam logic [7:0] CHR_DEL    = 8'h7F;

    // Weight of the most significant printed digit, and the saturation value
    localparam longint unsigned DIGIT_TOP = 10 ** (NUMBER_DIGITS - 1);
    localparam longint unsigned LINE_CAP  = DIGIT_TOP * 10 - 1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } text_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } text_out_t;

    typedef logic [OPT_COUNT-1:0] opt_set_t;

    // ------------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic                  cfg_wdata = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;     // [7:0] data_byte
    logic                  s_tuser   = 1'b0;   // [0] file_start
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;            // [7:0] out_byte
    logic                  m_tlast;            // last_of_run

    text_line_number_visualize_filter_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Formatter state, as it stands after reset
    // ------------------------------------------------------------------------
    logic            opt [OPT_COUNT] = '{default: 1'b0};
    longint unsigned line_count      = 1;
    logic            at_line_start   = 1'b1;
    logic [1:0]      blank_run       = '0;

    text_in_t  pending_q [$];   // bytes waiting for the driver
    text_out_t formatted_q [$]; // output bytes still owed by the block

    int unsigned send_gap_max = 0;
    int unsigned recv_gap_max = 0;
    int          hold_ask     = 0;   // bump to make the receiver hold off

    int fail_cnt     = 0;
    int bytes_in     = 0;
    int bytes_out    = 0;
    int numbered_cnt = 0;
    int squeezed_cnt = 0;
    int file_cnt     = 0;
    int settings_cnt = 0;

    // Format one accepted byte and append what it prints to formatted_q.
    function automatic void format_byte(input logic [7:0] byte_in, input logic new_file);
        logic [7:0]      c;
        logic [7:0]      text_q [$];
        longint unsigned weight;
        longint unsigned d;
        logic            leading;
        int              i;
        text_out_t       o;

        c = byte_in;
        if (new_file) begin
            // restart numbering and line tracking; options stay as written
            line_count    = 1;
            at_line_start = 1'b1;
            blank_run     = '0;
            file_cnt++;
        end

        // Count consecutive empty lines; the second one and beyond vanish
        if (opt[REG_SQUEEZE_BLANK] && c == CHR_NL && at_line_start) begin
            if (blank_run < 2) blank_run++;
        end else begin
            blank_run = '0;
        end
        if (blank_run > 1) begin
            squeezed_cnt++;
            return;
        end

        // Line number prefix; nonblank numbering wins over numbering everything
        if (at_line_start && ((opt[REG_NUMBER_NONBLANK] && c != CHR_NL) ||
                              (opt[REG_NUMBER_ALL] && !opt[REG_NUMBER_NONBLANK]))) begin
            weight  = DIGIT_TOP;
            leading = 1'b1;
            for (i = NUMBER_DIGITS - 1; i >= 0; i--) begin
                d = (line_count / weight) % 10;
                weight = weight / 10;
                if (d != 0 || i == 0) leading = 1'b0;
                text_q.push_back(leading ? CHR_SPACE : CHR_ZERO + 8'(d));
            end
            text_q.push_back(CHR_TAB);
            if (line_count < LINE_CAP) line_count++;
            numbered_cnt++;
        end

        // Visible tab turns into a letter, so it never gets a second caret
        if (opt[REG_SHOW_TABS] && c == CHR_TAB) begin
            text_q.push_back(CHR_CARET);
            c = CHR_LTR_I;
        end
        if (opt[REG_SHOW_ENDS] && c == CHR_NL) text_q.push_back(CHR_DOLLAR);
        if (opt[REG_SHOW_NONPRINTING] && (c < 8'h20 || c == CHR_DEL) &&
            c != CHR_NL && c != CHR_TAB) begin
            text_q.push_back(CHR_CARET);
            c = (c == CHR_DEL) ? CHR_QMARK : c + 8'h40;
        end
        text_q.push_back(c);
        at_line_start = (c == CHR_NL);

        foreach (text_q[k]) begin
            o.out_byte    = text_q[k];
            o.last_of_run = (k == text_q.size() - 1);
            formatted_q.push_back(o);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Input driver: pop the next byte when the slot frees, after its gap
    // ------------------------------------------------------------------------
    int unsigned send_wait = 0;

    always @(posedge aclk) begin : feed_bytes
        text_in_t nxt;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            send_wait <= 0;
        end else begin
            // predict at the accepting edge, from the values the block saw
            if (s_tvalid && s_tready) begin
                format_byte(s_tdata, s_tuser);
                bytes_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_wait != 0) begin
                    send_wait <= send_wait - 1;
                    s_tvalid  <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    nxt = pending_q.pop_front();
                    s_tdata   <= nxt.data_byte;
                    s_tuser   <= nxt.file_start;
                    s_tvalid  <= 1'b1;
                    send_wait <= $urandom_range(send_gap_max, 0);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor: check each accepted byte, then draw the next stall
    // ------------------------------------------------------------------------
    int unsigned recv_wait = 0;
    int unsigned recv_hold = 0;
    int          hold_seen = 0;

    always @(posedge aclk) begin : check_bytes
        text_out_t   want;
        int unsigned w;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_wait <= 0;
            recv_hold <= 0;
            hold_seen <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                bytes_out++;
                if (formatted_q.size() == 0) begin
                    $error("unexpected output byte %02h (last %0b)", m_tdata, m_tlast);
                    fail_cnt++;
                end else begin
                    want = formatted_q.pop_front();
                    if (m_tdata !== want.out_byte) begin
                        $error("out_byte: expected %02h, got %02h", want.out_byte, m_tdata);
                        fail_cnt++;
                    end
                    if (m_tlast !== want.last_of_run) begin
                        $error("last_of_run: expected %0b, got %0b",
                               want.last_of_run, m_tlast);
                        fail_cnt++;
                    end
                end
            end

            // long hold-off wins over the per-item stall
            if (hold_ask != hold_seen) begin
                hold_seen <= hold_ask;
                recv_hold <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else if (recv_hold != 0) begin
                recv_hold <= recv_hold - 1;
                m_tready  <= (recv_hold == 1);
            end else if (m_tvalid && m_tready) begin
                w = $urandom_range(recv_gap_max, 0);
                recv_wait <= w;
                m_tready  <= (w == 0);
            end else if (recv_wait != 0) begin
                recv_wait <= recv_wait - 1;
                m_tready  <= (recv_wait == 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b, input logic fs);
        text_in_t it;
        it.data_byte  = b;
        it.file_start = fs;
        pending_q.push_back(it);
    endtask

    // Hold until every byte is in and every output byte is out, then let
    // any squeezed trailing byte finish inside the block.
    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_q.size() != 0 || s_tvalid || formatted_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write all option registers; only called with the block idle.
    task automatic apply_options(input opt_set_t bits);
        cfg_reg_t r;
        r = r.first();
        repeat (r.num()) begin
            @(posedge aclk);
            cfg_we    <= 1'b1;
            cfg_addr  <= r;
            cfg_wdata <= bits[r];
            opt[r] = bits[r];
            r = r.next();
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_cnt++;
    endtask

    // Text-like byte mix: lines, tabs, control codes, DEL, high bytes, noise
    function automatic logic [7:0] text_byte();
        int unsigned p;
        p = $urandom_range(99, 0);
        if (p < 18)      return CHR_NL;
        else if (p < 26) return CHR_TAB;
        else if (p < 34) return 8'($urandom_range(31, 0));
        else if (p < 37) return CHR_DEL;
        else if (p < 45) return 8'($urandom_range(255, 128));
        else if (p < 55) return 8'($urandom);
        else             return 8'($urandom_range(126, 32));
    endfunction

    function automatic int unsigned gap_choice();
        int unsigned p;
        p = $urandom_range(9, 0);
        if (p < 3)      return 0;
        else if (p < 7) return GAP_MAX;
        else            return $urandom_range(GAP_MAX - 1, 1);
    endfunction

    task automatic queue_text(input int n);
        repeat (n) begin
            // occasional runs of blank lines to exercise squeezing
            if ($urandom_range(9, 0) == 0) begin
                repeat ($urandom_range(4, 2)) queue_byte(CHR_NL, 1'b0);
            end else begin
                queue_byte(text_byte(), $urandom_range(24, 0) == 0);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : run_text
        opt_set_t set;
        int       n;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Defaults: everything passes through untouched
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(CHR_TAB, 1'b0);
        queue_byte(CHR_DEL, 1'b0);
        queue_byte(CHR_NL, 1'b0);
        wait_idle();

        // Every option on: blank runs squeeze, nonblank numbering overrides,
        // tab shown once as caret-I, control extremes, file restart
        send_gap_max = GAP_MAX;
        recv_gap_max = GAP_MAX;
        apply_options('1);
        queue_byte(CHR_NL, 1'b0);
        queue_byte(CHR_NL, 1'b0);
        queue_byte(CHR_NL, 1'b0);
        queue_byte(8'h78, 1'b0);
        queue_byte(CHR_TAB, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h1F, 1'b0);
        queue_byte(CHR_DEL, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(CHR_NL, 1'b0);
        queue_byte(8'h61, 1'b1);
        queue_byte(CHR_NL, 1'b0);
        wait_idle();

        // Number all lines, control bytes visible, tab left alone
        send_gap_max = 3;
        recv_gap_max = 0;
        set = '0;
        set[REG_NUMBER_ALL]       = 1'b1;
        set[REG_SHOW_NONPRINTING] = 1'b1;
        apply_options(set);
        queue_byte(CHR_NL, 1'b0);
        queue_byte(CHR_NL, 1'b0);
        queue_byte(CHR_TAB, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h62, 1'b0);
        queue_byte(CHR_NL, 1'b0);
        wait_idle();

        // Random text under a series of settings, extremes first
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 0)      set = '1;
            else if (ph == 1) set = '0;
            else              set = opt_set_t'($urandom);
            send_gap_max = gap_choice();
            recv_gap_max = gap_choice();
            apply_options(set);
            n = $urandom_range(30, 20);
            queue_text(n / 2);
            // sometimes let the output catch up completely mid-phase
            if ($urandom_range(2, 0) == 0) wait_idle();
            queue_text(n - n / 2);
            wait_idle();
        end

        // Back-pressure: sender streams flat out while the receiver holds off
        send_gap_max = 0;
        recv_gap_max = 0;
        set = '1;
        set[REG_NUMBER_NONBLANK] = 1'b0;
        apply_options(set);
        queue_text(50);
        hold_ask++;
        wait_idle();

        $display("Filtered %0d input bytes into %0d output bytes over %0d option settings.",
                 bytes_in, bytes_out, settings_cnt);
        $display("Saw %0d numbered lines, %0d squeezed newlines and %0d file restarts.",
                 numbered_cnt, squeezed_cnt, file_cnt);
        if (fail_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Hard stop in case the stream hangs
    initial begin : watchdog
        #(LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
